### rtl/rllt_pkg.sv
// ----------------------------------------------------------------------------
// rllt_pkg
// Shared types and codes for the run-length line table.
// ----------------------------------------------------------------------------
`default_nettype none

package rllt_pkg;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [15:0] line_number;
    logic [15:0] offset;
  } rllt_req_t;

  typedef struct packed {
    logic [15:0] found_line;
    logic [1:0]  status;
  } rllt_rsp_t;

  // lookup token walking down the cell row
  typedef struct packed {
    logic        valid;
    logic        done;
    logic [15:0] line;
  } rllt_tok_t;

  // broadcast write into one cell
  typedef struct packed {
    logic        en;
    logic        fresh;
    logic [15:0] line;
  } rllt_wr_t;

endpackage

`default_nettype wire

### rtl/rllt_cell.sv
// ----------------------------------------------------------------------------
// rllt_cell
// One run of the table: line and length, plus one stage of the lookup walk.
// ----------------------------------------------------------------------------
`default_nettype none

module rllt_cell #(
  parameter int MAX_RUNS    = 256,
  parameter int MAX_OFFSETS = 65536,
  parameter int INDEX       = 0
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire rllt_pkg::rllt_wr_t                   wr,
  input  wire logic [$clog2(MAX_RUNS)-1:0]          wr_idx,
  input  wire logic [$clog2(MAX_RUNS+1)-1:0]        count,
  input  wire logic [15:0]                          offset,
  input  wire rllt_pkg::rllt_tok_t                  tok_in,
  input  wire logic [$clog2(MAX_OFFSETS+1)-1:0]     sum_in,
  output rllt_pkg::rllt_tok_t                       tok_out,
  output logic [$clog2(MAX_OFFSETS+1)-1:0]          sum_out
);
  import rllt_pkg::*;

  localparam int IDX_W = $clog2(MAX_RUNS);
  localparam int CNT_W = $clog2(MAX_RUNS + 1);
  localparam int SUM_W = $clog2(MAX_OFFSETS + 1);
  localparam int CMP_W = (SUM_W > 16) ? SUM_W : 16;

  logic [15:0]    run_line;
  logic [SUM_W-1:0] run_len;
  logic           active;
  logic           hit;
  logic [SUM_W-1:0] sum_add;

  assign active  = (count > CNT_W'(INDEX));
  assign sum_add = sum_in + run_len;
  assign hit     = tok_in.valid && !tok_in.done && active &&
                   (CMP_W'(sum_add) > CMP_W'(offset));

  // run storage, written only through the broadcast port
  always_ff @(posedge clk) begin
    if (wr.en && (wr_idx == IDX_W'(INDEX))) begin
      if (wr.fresh) begin
        run_line <= wr.line;
        run_len  <= SUM_W'(1);
      end else begin
        run_len  <= run_len + SUM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.done <= tok_in.done | hit;
    tok_out.line <= hit ? run_line : tok_in.line;
    sum_out      <= active ? sum_add : sum_in;
  end

endmodule

`default_nettype wire

### rtl/run_length_line_table.sv
// ----------------------------------------------------------------------------
// run_length_line_table
// Run-length table from code offsets to source lines, one run per cell.
// ----------------------------------------------------------------------------
// Record: S_REC and S_DONE lie between the request transfer and the registered
// response; ready returns with it. Lookup: the token crosses a register per
// cell, then S_WALK and S_DONE; it passes every cell of the row once.
// One item in flight; a new request is taken while a response waits.
// Reset (rst, synchronous) empties the table: run count and offset total go
// to zero. Run contents are not cleared; entries past the count are ignored.
`default_nettype none

module run_length_line_table #(
  parameter int MAX_RUNS    = 256,
  parameter int MAX_OFFSETS = 65536
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire rllt_pkg::rllt_req_t req,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output rllt_pkg::rllt_rsp_t      rsp
);
  import rllt_pkg::*;

  localparam int IDX_W = $clog2(MAX_RUNS);
  localparam int CNT_W = $clog2(MAX_RUNS + 1);
  localparam int SUM_W = $clog2(MAX_OFFSETS + 1);

  typedef enum logic [1:0] {S_IDLE, S_REC, S_WALK, S_DONE} state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] cnt_m1;
  logic [SUM_W-1:0] offs;
  logic [15:0]      last_line;
  logic [15:0]      line_q;
  logic [15:0]      off_q;
  logic             start;
  logic [15:0]      pend_line;
  logic [1:0]       pend_status;
  logic [1:0]       rec_status;
  rllt_wr_t         wr;
  logic [IDX_W-1:0] wr_idx;

  rllt_tok_t        tok_chain [0:MAX_RUNS];
  logic [SUM_W-1:0] sum_chain [0:MAX_RUNS];
  rllt_tok_t        tail_tok;

  assign req_ready = (state == S_IDLE);
  assign cnt_m1    = count - CNT_W'(1);

  always_comb begin
    wr         = '{en: 1'b0, fresh: 1'b0, line: line_q};
    wr_idx     = count[IDX_W-1:0];
    rec_status = ST_OK;
    if (offs == SUM_W'(MAX_OFFSETS)) begin
      rec_status = ST_FULL;
    end else if ((count != '0) && (last_line == line_q)) begin
      wr.en  = 1'b1;
      wr_idx = cnt_m1[IDX_W-1:0];
    end else if (count == CNT_W'(MAX_RUNS)) begin
      rec_status = ST_FULL;
    end else begin
      wr.en    = 1'b1;
      wr.fresh = 1'b1;
    end
    if (state != S_REC) begin
      wr.en = 1'b0;
    end
  end

  assign tok_chain[0] = '{valid: start, done: 1'b0, line: 16'd0};
  assign sum_chain[0] = '0;
  assign tail_tok     = tok_chain[MAX_RUNS];

  for (genvar g = 0; g < MAX_RUNS; g++) begin : g_cell
    rllt_cell #(
      .MAX_RUNS    (MAX_RUNS),
      .MAX_OFFSETS (MAX_OFFSETS),
      .INDEX       (g)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .wr      (wr),
      .wr_idx  (wr_idx),
      .count   (count),
      .offset  (off_q),
      .tok_in  (tok_chain[g]),
      .sum_in  (sum_chain[g]),
      .tok_out (tok_chain[g+1]),
      .sum_out (sum_chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      count     <= '0;
      offs      <= '0;
      start     <= 1'b0;
    end else begin
      start <= (state == S_IDLE) && req_valid && (req.opcode == OP_LOOKUP);
      // S_DONE reloads the slot itself when it empties
      if (rsp_valid && rsp_ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            line_q <= req.line_number;
            off_q  <= req.offset;
            if (req.opcode == OP_LOOKUP) begin
              state <= S_WALK;
            end else begin
              state <= S_REC;
            end
          end
        end
        S_REC: begin
          pend_line   <= 16'd0;
          pend_status <= rec_status;
          if (wr.en) begin
            offs <= offs + SUM_W'(1);
            if (wr.fresh) begin
              count     <= count + CNT_W'(1);
              last_line <= line_q;
            end
          end
          state <= S_DONE;
        end
        S_WALK: begin
          if (tail_tok.valid) begin
            pend_line   <= tail_tok.done ? tail_tok.line : 16'd0;
            pend_status <= tail_tok.done ? ST_OK : ST_NOT_FOUND;
            state       <= S_DONE;
          end
        end
        S_DONE: begin
          // output slot free or emptying this cycle
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            rsp       <= '{found_line: pend_line, status: pend_status};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_RUNS))
    else $error("run count past capacity");

  a_offs_bound: assert property (@(posedge clk) disable iff (rst)
    offs <= SUM_W'(MAX_OFFSETS))
    else $error("offset total past budget");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("second request taken while busy");

  a_tail_in_walk: assert property (@(posedge clk) disable iff (rst)
    tail_tok.valid |-> (state == S_WALK))
    else $error("lookup token left the row outside a walk");

endmodule

`default_nettype wire
